/* src/playfair_digraph_cipher_macros.svh */
// ----------------------------------------------------------------------------
// Playfair digraph cipher assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH

// cond must never hold at a clock edge
`define PFC_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// ante at an edge implies cons at the same edge
`define PFC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* src/pfc_pkg.sv */
// ----------------------------------------------------------------------------
// pfc_pkg
// Types, constants and helper functions of the Playfair digraph cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package pfc_pkg;

	localparam int Side      = 5;
	localparam int LetterW   = 5;
	localparam int RcW       = 3;
	localparam int CellCount = Side * Side;
	localparam int SquareW   = CellCount * LetterW;
	localparam int CfgDataW  = 60;
	localparam int CfgIdxW   = 3;
	localparam int CmdDepth  = 4;
	localparam int CmdPtrW   = 2;
	localparam int CmdCntW   = 3;

	typedef logic [LetterW-1:0] letter_t;
	typedef logic [RcW-1:0]     rc_t;
	typedef logic [SquareW-1:0] square_t;

	localparam letter_t LetterI = letter_t'(8);
	localparam letter_t LetterJ = letter_t'(9);
	localparam letter_t LetterQ = letter_t'(16);
	localparam letter_t LetterX = letter_t'(23);
	localparam letter_t PadReset = LetterX;
	localparam rc_t     RcLast  = rc_t'(Side - 1);

	typedef enum logic [CfgIdxW-1:0] {
		CfgMode  = 3'd0,
		CfgPad   = 3'd1,
		CfgLow   = 3'd2,
		CfgMid   = 3'd3,
		CfgFinal = 3'd4
	} cfg_reg_t;

	// one letter pair handed from front to back
	typedef struct packed {
		letter_t letter_a;
		letter_t letter_b;
		logic    run_end;
		logic    msg_done;
	} pair_t;

	typedef struct packed {
		rc_t row;
		rc_t col;
	} pos_t;

	// Cell position of a letter; J maps to I; last match wins; no match is cell 0
	function automatic pos_t locate(input square_t square, input letter_t letter);
		letter_t key;
		pos_t    pos;
		key = (letter == LetterJ) ? LetterI : letter;
		pos = '0;
		for (int r = 0; r < Side; r++) begin
			for (int c = 0; c < Side; c++) begin
				if (square[(r*Side + c)*LetterW +: LetterW] == key) begin
					pos.row = rc_t'(r);
					pos.col = rc_t'(c);
				end
			end
		end
		return pos;
	endfunction

	// Step one place round the square: forward for encrypt, back for decrypt
	function automatic rc_t wrap_step(input rc_t v, input logic dec);
		rc_t res;
		if (dec) begin
			res = (v == '0) ? RcLast : rc_t'(v - rc_t'(1));
		end else begin
			res = (v == RcLast) ? '0 : rc_t'(v + rc_t'(1));
		end
		return res;
	endfunction

	function automatic letter_t cell_pick(input square_t square, input pos_t pos);
		logic [6:0] idx;
		idx = 7'(pos.row) * 7'(Side) + 7'(pos.col);
		return square[idx*LetterW +: LetterW];
	endfunction

endpackage

`default_nettype wire

/* src/pfc_front.sv */
// ----------------------------------------------------------------------------
// pfc_front
// Takes letters in, forms digraphs and queues one pair command per pair.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_front import pfc_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	output logic         full,
	input  wire letter_t letter,
	input  wire logic    message_end,
	input  wire logic    cipher_mode,
	input  wire letter_t pad_letter,
	output logic         cmd_push,
	output pair_t        cmd_data,
	input  wire logic    cmd_full
);

	logic    held_valid_q;
	letter_t held_letter_q;
	logic    pend_valid_q;
	pair_t   pend_q;

	logic    accept;
	logic    doubled;
	logic    acc_cmd;
	pair_t   acc_pair;
	logic    held_valid_d;
	letter_t held_letter_d;
	logic    pend_valid_d;

	// a pending pad pair blocks new letters until the pair queue takes it
	assign full    = pend_valid_q || cmd_full;
	assign accept  = push && !full;
	assign doubled = !cipher_mode && (letter == held_letter_q);

	always_comb begin
		acc_cmd       = 1'b0;
		acc_pair      = '0;
		held_valid_d  = held_valid_q;
		held_letter_d = held_letter_q;
		pend_valid_d  = 1'b0;
		priority if (!held_valid_q) begin
			if (message_end) begin
				acc_cmd  = 1'b1;
				acc_pair = '{letter_a: letter, letter_b: pad_letter,
					run_end: 1'b1, msg_done: 1'b1};
			end else begin
				held_valid_d  = 1'b1;
				held_letter_d = letter;
			end
		end else if (!doubled) begin
			acc_cmd       = 1'b1;
			acc_pair      = '{letter_a: held_letter_q, letter_b: letter,
				run_end: 1'b1, msg_done: message_end};
			held_valid_d  = 1'b0;
			held_letter_d = '0;
		end else begin
			acc_cmd  = 1'b1;
			acc_pair = '{letter_a: held_letter_q,
				letter_b: (held_letter_q == LetterQ) ? LetterX : LetterQ,
				run_end: !message_end, msg_done: 1'b0};
			if (message_end) begin
				// repeated letter closes the message as a padded pair
				pend_valid_d  = 1'b1;
				held_valid_d  = 1'b0;
				held_letter_d = '0;
			end
		end
	end

	assign cmd_push = (pend_valid_q && !cmd_full) || (accept && acc_cmd);
	assign cmd_data = pend_valid_q ? pend_q : acc_pair;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q  <= 1'b0;
			held_letter_q <= '0;
			pend_valid_q  <= 1'b0;
		end else begin
			if (pend_valid_q && !cmd_full) begin
				pend_valid_q <= 1'b0;
			end
			if (accept) begin
				held_valid_q  <= held_valid_d;
				held_letter_q <= held_letter_d;
				pend_valid_q  <= pend_valid_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && pend_valid_d) begin
			pend_q <= '{letter_a: letter, letter_b: pad_letter,
				run_end: 1'b1, msg_done: 1'b1};
		end
	end

endmodule

`default_nettype wire

/* src/pfc_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// pfc_cmd_fifo
// Short queue of pair commands between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_cmd_fifo import pfc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  wr_en,
	input  wire pair_t wr_data,
	output logic       full,
	input  wire logic  rd_en,
	output pair_t      rd_data,
	output logic       empty,
	output logic [CmdCntW-1:0] count
);

	pair_t              entries_q [CmdDepth];
	logic [CmdPtrW-1:0] wr_ptr_q;
	logic [CmdPtrW-1:0] rd_ptr_q;
	logic [CmdCntW-1:0] count_q;
	logic               do_wr;
	logic               do_rd;

	assign full    = (count_q == CmdCntW'(CmdDepth));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + CmdPtrW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + CmdPtrW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CmdCntW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CmdCntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

/* src/pfc_back.sv */
// ----------------------------------------------------------------------------
// pfc_back
// Looks pairs up in the key square, applies the pair rules and sends out
// the two letters one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_back import pfc_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    cipher_mode,
	input  wire square_t square,
	input  wire pair_t   cmd_data,
	input  wire logic    cmd_empty,
	output logic         cmd_pop,
	output logic         empty,
	input  wire logic    pop,
	output letter_t      out_letter,
	output logic         run_end,
	output logic         message_done
);

	// stage 1: positions of both letters
	logic valid_s1;
	pos_t pa_s1;
	pos_t pb_s1;
	logic run_end_s1;
	logic done_s1;

	// stage 2: both result letters, sent first then second
	logic    valid_s2;
	logic    phase_s2;
	letter_t la_s2;
	letter_t lb_s2;
	logic    run_end_s2;
	logic    done_s2;

	logic s2_free;
	logic adv_s1;
	logic ready_s1;
	pos_t xa;
	pos_t xb;

	assign s2_free  = !valid_s2 || (pop && phase_s2);
	assign adv_s1   = valid_s1 && s2_free;
	assign ready_s1 = !valid_s1 || adv_s1;
	assign cmd_pop  = !cmd_empty && ready_s1;

	always_comb begin
		priority if (pa_s1.row == pb_s1.row) begin
			// also covers a pair sitting on one cell
			xa = '{row: pa_s1.row, col: wrap_step(pa_s1.col, cipher_mode)};
			xb = '{row: pb_s1.row, col: wrap_step(pb_s1.col, cipher_mode)};
		end else if (pa_s1.col == pb_s1.col) begin
			xa = '{row: wrap_step(pa_s1.row, cipher_mode), col: pa_s1.col};
			xb = '{row: wrap_step(pb_s1.row, cipher_mode), col: pb_s1.col};
		end else begin
			xa = '{row: pa_s1.row, col: pb_s1.col};
			xb = '{row: pb_s1.row, col: pa_s1.col};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			phase_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= cmd_pop;
			end
			if (s2_free) begin
				valid_s2 <= adv_s1;
				phase_s2 <= 1'b0;
			end else if (pop) begin
				phase_s2 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			pa_s1      <= locate(square, cmd_data.letter_a);
			pb_s1      <= locate(square, cmd_data.letter_b);
			run_end_s1 <= cmd_data.run_end;
			done_s1    <= cmd_data.msg_done;
		end
		if (adv_s1) begin
			la_s2      <= cell_pick(square, xa);
			lb_s2      <= cell_pick(square, xb);
			run_end_s2 <= run_end_s1;
			done_s2    <= done_s1;
		end
	end

	assign empty        = !valid_s2;
	assign out_letter   = phase_s2 ? lb_s2 : la_s2;
	assign run_end      = phase_s2 && run_end_s2;
	assign message_done = phase_s2 && done_s2;

endmodule

`default_nettype wire

/* src/playfair_digraph_cipher.sv */
// ----------------------------------------------------------------------------
// playfair_digraph_cipher
// Playfair cipher over a 5x5 key square, one letter in, letters out.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive letter and message_end with push; a transfer
//   happens at an edge with push high and full low. Output side is a queue:
//   while empty is low, out_letter/run_end/message_done show the oldest
//   result; pop high at an edge transfers it.
//   Configuration is written through cfg_write/cfg_index/cfg_data while idle:
//   0 mode, 1 pad letter, 2 cells 0-11, 3 cells 12-23, 4 cell 24.
//   The first letter of a pair is shown once the completed pair has passed
//   the pair queue and stages 1 and 2; the second follows on the next pop.
//   Throughput: the back end delivers one letter per cycle while pop is held
//   high; an input that closes a doubled letter at message end makes two
//   pairs and holds full high until the second pair is in the pair queue.
//   A four-entry pair queue sits between front and back, so letters keep
//   being taken while the receiver stalls until that queue fills.
//   Reset clears the held letter, the queues and loads the register
//   defaults (encrypt, pad X, square all A).
// ----------------------------------------------------------------------------
`default_nettype none

`include "playfair_digraph_cipher_macros.svh"

module playfair_digraph_cipher import pfc_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire letter_t             letter,
	input  wire logic                message_end,
	output logic                     empty,
	input  wire logic                pop,
	output letter_t                  out_letter,
	output logic                     run_end,
	output logic                     message_done,
	input  wire logic                cfg_write,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data
);

	logic                cipher_mode_q;
	letter_t             pad_letter_q;
	logic [CfgDataW-1:0] cells_low_q;
	logic [CfgDataW-1:0] cells_mid_q;
	letter_t             cell_final_q;
	square_t             square;

	logic               cmd_push;
	pair_t              cmd_wdata;
	logic               cmd_full;
	logic               cmd_pop;
	pair_t              cmd_rdata;
	logic               cmd_empty;
	logic [CmdCntW-1:0] cmd_count;

	// register file; cell k sits at bits 5k of the packed square
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cipher_mode_q <= 1'b0;
			pad_letter_q  <= PadReset;
			cells_low_q   <= '0;
			cells_mid_q   <= '0;
			cell_final_q  <= '0;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				CfgMode:  cipher_mode_q <= cfg_data[0];
				CfgPad:   pad_letter_q  <= cfg_data[LetterW-1:0];
				CfgLow:   cells_low_q   <= cfg_data;
				CfgMid:   cells_mid_q   <= cfg_data;
				CfgFinal: cell_final_q  <= cfg_data[LetterW-1:0];
				default:  ;
			endcase
		end
	end

	assign square = {cell_final_q, cells_mid_q, cells_low_q};

	// front: digraph forming, filler and pad insertion
	pfc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.letter     (letter),
		.message_end(message_end),
		.cipher_mode(cipher_mode_q),
		.pad_letter (pad_letter_q),
		.cmd_push   (cmd_push),
		.cmd_data   (cmd_wdata),
		.cmd_full   (cmd_full)
	);

	pfc_cmd_fifo u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_data(cmd_wdata),
		.full   (cmd_full),
		.rd_en  (cmd_pop),
		.rd_data(cmd_rdata),
		.empty  (cmd_empty),
		.count  (cmd_count)
	);

	// back: square lookup, pair rules, letter-serial output
	pfc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cipher_mode (cipher_mode_q),
		.square      (square),
		.cmd_data    (cmd_rdata),
		.cmd_empty   (cmd_empty),
		.cmd_pop     (cmd_pop),
		.empty       (empty),
		.pop         (pop),
		.out_letter  (out_letter),
		.run_end     (run_end),
		.message_done(message_done)
	);

	`PFC_ASSERT_NEVER(a_done_without_end, !empty && message_done && !run_end, "done without end")
	`PFC_ASSERT_NEVER(a_cmd_overflow, cmd_count > CmdCntW'(CmdDepth), "pair queue past depth")
	`PFC_ASSERT_IMPL(a_push_into_full, cmd_push, !cmd_full, "pair pushed into full queue")

endmodule

`default_nettype wire
